// ----- rtl/core/rhsl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsl_pkg: shared types and constants for the RGB to hue/saturation/luma core
// Field widths, luma weights, divider sizing and the divider stage record.
// ----------------------------------------------------------------------------
package rhsl_pkg;

	// pixel and result field widths
	localparam int PIX_W   = 8;
	localparam int HUE_W   = 16;
	localparam int SAT_W   = 16;
	localparam int LUMA_W  = 8;

	// hue fixed point: fractional bits produced by the hue divider
	localparam int FRAC_BITS = 16;

	// divider stage count covers the longer of the two quotients
	localparam int DIV_STAGES = (FRAC_BITS > SAT_W) ? FRAC_BITS : SAT_W;

	// luma weights, sum of weights times 255 fits in 16 bits
	localparam int                LSUM_W = 16;
	localparam logic [LSUM_W-1:0] COEF_R = 16'd76;
	localparam logic [LSUM_W-1:0] COEF_G = 16'd150;
	localparam logic [LSUM_W-1:0] COEF_B = 16'd29;
	localparam logic [LUMA_W-1:0] LUMA_MID = 8'd127;

	// hue divider: divisor 6*d up to 1530, partial remainder doubled below 4096
	localparam int HDIV_W = 11;
	localparam int HREM_W = 12;

	// saturation divider: divisor up to 510, dividend d*65535 on 24 bits
	localparam int                SDIV_W   = 9;
	localparam int                SNUM_W   = PIX_W + SAT_W;
	localparam logic [SDIV_W-1:0] SUM_FULL = 9'd510;

	// channel holding the maximum, red before green before blue
	typedef enum logic [1:0] {
		SEXT_RED,
		SEXT_GREEN,
		SEXT_BLUE
	} sext_t;

	// one divider stage: both long divisions plus the fields riding along
	typedef struct packed {
		logic [HREM_W-1:0]    hue_rem;
		logic [HDIV_W-1:0]    hue_div;
		logic [FRAC_BITS-1:0] hue_quo;
		logic [SDIV_W-1:0]    sat_rem;
		logic [SDIV_W-1:0]    sat_div;
		logic [SAT_W-1:0]     sat_low;
		logic [SAT_W-1:0]     sat_quo;
		logic [LUMA_W-1:0]    luma;
		logic                 grey;
	} div_t;

endpackage

// ----- rtl/core/rhsl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsl_if: valid/ready channels of the RGB to hue/saturation/luma core
// Pixel request channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface rhsl_pix_if;
	logic                        valid;
	logic                        ready;
	logic [rhsl_pkg::PIX_W-1:0]  red;
	logic [rhsl_pkg::PIX_W-1:0]  green;
	logic [rhsl_pkg::PIX_W-1:0]  blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsl_res_if;
	logic                        valid;
	logic                        ready;
	logic [rhsl_pkg::HUE_W-1:0]  hue_turn;
	logic [rhsl_pkg::SAT_W-1:0]  saturation_frac;
	logic [rhsl_pkg::LUMA_W-1:0] luma_level;
	logic                        is_grey;

	modport source (output valid, output hue_turn, output saturation_frac,
		output luma_level, output is_grey, input ready);
	modport sink   (input valid, input hue_turn, input saturation_frac,
		input luma_level, input is_grey, output ready);
endinterface

// ----- rtl/core/rgb_hue_saturation_luma.sv -----
`timescale 1ns / 1ps
// Throughput: one pixel per cycle unless the output stalls; the hue and
// saturation quotients are built one bit per stage by two restoring
// dividers running side by side. A full output register that is not being
// read stalls the whole pipeline as one.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_hue_saturation_luma: pipelined RGB to hue, saturation and luma
// Stage 1 finds max/min and luma, stage 2 sets up both divisions, then one
// quotient bit per stage; the output register zeroes grey hue and saturation.
// ----------------------------------------------------------------------------
module rgb_hue_saturation_luma (
	input  logic       clk,
	input  logic       arst_n,
	rhsl_pix_if.sink   pix,
	rhsl_res_if.source res
);
	import rhsl_pkg::*;

	// pipeline advance: the output register is free or being emptied
	logic adv;

	// stage 1
	logic                vld_s1;
	logic [PIX_W-1:0]    hi_s1;
	logic [PIX_W-1:0]    lo_s1;
	logic [LUMA_W-1:0]   luma_s1;
	logic                grey_s1;
	sext_t               sext_s1;
	logic signed [PIX_W:0] diff_s1;

	// stage 2 and the divider stages after it
	logic vld_sd [0:DIV_STAGES];
	div_t div_sd [0:DIV_STAGES];

	// output register
	logic              out_vld_q;
	logic [HUE_W-1:0]  hue_q;
	logic [SAT_W-1:0]  sat_q;
	logic [LUMA_W-1:0] luma_q;
	logic              grey_q;

	assign adv       = !out_vld_q || res.ready;
	assign pix.ready = adv;

	// ------------------------------------------------------------------
	// Stage 1: max, min, luma and the channel holding the maximum
	// ------------------------------------------------------------------
	logic [PIX_W-1:0]  hi_c;
	logic [PIX_W-1:0]  lo_c;
	logic [LSUM_W-1:0] lsum_c;
	sext_t             sext_c;
	logic signed [PIX_W:0] diff_c;

	always_comb begin
		lsum_c = COEF_R * LSUM_W'(pix.red) + COEF_G * LSUM_W'(pix.green)
			+ COEF_B * LSUM_W'(pix.blue);
		if (pix.red >= pix.green && pix.red >= pix.blue) begin
			sext_c = SEXT_RED;
			hi_c   = pix.red;
		end else if (pix.green >= pix.blue) begin
			sext_c = SEXT_GREEN;
			hi_c   = pix.green;
		end else begin
			sext_c = SEXT_BLUE;
			hi_c   = pix.blue;
		end
		lo_c = pix.red;
		if (pix.green < lo_c) begin
			lo_c = pix.green;
		end
		if (pix.blue < lo_c) begin
			lo_c = pix.blue;
		end
		// difference of the two other channels, in sextant order
		unique case (sext_c)
			SEXT_RED:   diff_c = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
			SEXT_GREEN: diff_c = $signed({1'b0, pix.blue})  - $signed({1'b0, pix.red});
			SEXT_BLUE:  diff_c = $signed({1'b0, pix.red})   - $signed({1'b0, pix.green});
			default:    diff_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hi_s1   <= hi_c;
			lo_s1   <= lo_c;
			luma_s1 <= lsum_c[LSUM_W-1:LSUM_W-LUMA_W];
			grey_s1 <= (hi_c == lo_c);
			sext_s1 <= sext_c;
			diff_s1 <= diff_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: spread, divisors, wrapped hue numerator, saturation dividend
	// ------------------------------------------------------------------
	logic [PIX_W-1:0]         d_c;
	logic [SDIV_W-1:0]        sum_c;
	logic [HDIV_W-1:0]        six_d_c;
	logic signed [HREM_W-1:0] base_c;
	logic signed [HREM_W-1:0] num_c;
	logic [SNUM_W-1:0]        snum_c;
	div_t                     set_c;

	always_comb begin
		d_c     = hi_s1 - lo_s1;
		sum_c   = SDIV_W'(hi_s1) + SDIV_W'(lo_s1);
		six_d_c = (HDIV_W'(d_c) << 2) + (HDIV_W'(d_c) << 1);
		unique case (sext_s1)
			SEXT_RED:   base_c = '0;
			SEXT_GREEN: base_c = $signed(HREM_W'(d_c) << 1);
			SEXT_BLUE:  base_c = $signed(HREM_W'(d_c) << 2);
			default:    base_c = '0;
		endcase
		num_c = base_c + HREM_W'(diff_s1);
		// wrap a negative hue by one turn
		if (num_c[HREM_W-1]) begin
			num_c = num_c + $signed(HREM_W'(six_d_c));
		end
		snum_c = (SNUM_W'(d_c) << SAT_W) - SNUM_W'(d_c);

		set_c         = '0;
		set_c.hue_rem = num_c;
		set_c.hue_div = six_d_c;
		set_c.sat_div = (luma_s1 <= LUMA_MID) ? sum_c : SUM_FULL - sum_c;
		// top byte of the dividend is already below the divisor
		set_c.sat_rem = SDIV_W'(snum_c[SNUM_W-1:SAT_W]);
		set_c.sat_low = snum_c[SAT_W-1:0];
		set_c.luma    = luma_s1;
		set_c.grey    = grey_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else if (adv) begin
			vld_sd[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_sd[0] <= set_c;
		end
	end

	// ------------------------------------------------------------------
	// Divider stages: one hue bit and one saturation bit per stage
	// ------------------------------------------------------------------
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		div_t              nxt;
		logic [HREM_W-1:0] ht;
		logic [SDIV_W:0]   st;

		always_comb begin
			nxt = div_sd[i];
			ht  = {div_sd[i].hue_rem[HREM_W-2:0], 1'b0};
			st  = {div_sd[i].sat_rem, div_sd[i].sat_low[SAT_W-1]};
			if (i < FRAC_BITS) begin
				if (ht >= HREM_W'(div_sd[i].hue_div)) begin
					nxt.hue_rem = ht - HREM_W'(div_sd[i].hue_div);
					nxt.hue_quo = {div_sd[i].hue_quo[FRAC_BITS-2:0], 1'b1};
				end else begin
					nxt.hue_rem = ht;
					nxt.hue_quo = {div_sd[i].hue_quo[FRAC_BITS-2:0], 1'b0};
				end
			end
			if (i < SAT_W) begin
				nxt.sat_low = {div_sd[i].sat_low[SAT_W-2:0], 1'b0};
				if (st >= (SDIV_W+1)'(div_sd[i].sat_div)) begin
					nxt.sat_rem = SDIV_W'(st - (SDIV_W+1)'(div_sd[i].sat_div));
					nxt.sat_quo = {div_sd[i].sat_quo[SAT_W-2:0], 1'b1};
				end else begin
					nxt.sat_rem = SDIV_W'(st);
					nxt.sat_quo = {div_sd[i].sat_quo[SAT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[i+1] <= 1'b0;
			end else if (adv) begin
				vld_sd[i+1] <= vld_sd[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_sd[i+1] <= nxt;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register: force hue and saturation to zero for grey pixels
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_sd[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_q  <= div_sd[DIV_STAGES].grey ? '0 : HUE_W'(div_sd[DIV_STAGES].hue_quo);
			sat_q  <= div_sd[DIV_STAGES].grey ? '0 : div_sd[DIV_STAGES].sat_quo;
			luma_q <= div_sd[DIV_STAGES].luma;
			grey_q <= div_sd[DIV_STAGES].grey;
		end
	end

	assign res.valid           = out_vld_q;
	assign res.hue_turn        = hue_q;
	assign res.saturation_frac = sat_q;
	assign res.luma_level      = luma_q;
	assign res.is_grey         = grey_q;

endmodule
